[hdl/triac_phase_angle_controller_core_assert.svh]
// assertion macros for the rtl
// clk and rst_n must be visible where these are used
`ifndef TRIAC_PHASE_ANGLE_CONTROLLER_CORE_ASSERT_SVH
`define TRIAC_PHASE_ANGLE_CONTROLLER_CORE_ASSERT_SVH

// same-cycle implication
`define TPAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TPAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/tpac_pkg.sv]
package tpac_pkg;

  // event codes
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_ZCROSS = 2'd1;
  localparam logic [1:0] ACT_KEY    = 2'd2;

  localparam logic [6:0] PWR_MIN   = 7'd1;
  localparam logic [6:0] PWR_MAX   = 7'd99;
  localparam logic [6:0] PWR_RESET = 7'd50;

  localparam logic [15:0] COUNT_LAST = 16'hFFFF;

  localparam int TABLE_ENTRIES = 101;

  // reload values, indexed by power level
  localparam logic [15:0] DELAY_TABLE [TABLE_ENTRIES] = '{
    16'd57342, 16'd58170, 16'd58427, 16'd58610, 16'd58759,
    16'd58886, 16'd58998, 16'd59099, 16'd59192, 16'd59279,
    16'd59360, 16'd59437, 16'd59510, 16'd59580, 16'd59647,
    16'd59711, 16'd59774, 16'd59834, 16'd59892, 16'd59950,
    16'd60005, 16'd60060, 16'd60113, 16'd60165, 16'd60216,
    16'd60266, 16'd60316, 16'd60364, 16'd60412, 16'd60460,
    16'd60506, 16'd60552, 16'd60598, 16'd60643, 16'd60688,
    16'd60732, 16'd60776, 16'd60820, 16'd60863, 16'd60906,
    16'd60949, 16'd60992, 16'd61034, 16'd61077, 16'd61119,
    16'd61161, 16'd61203, 16'd61244, 16'd61286, 16'd61328,
    16'd61369, 16'd61411, 16'd61453, 16'd61494, 16'd61536,
    16'd61578, 16'd61620, 16'd61662, 16'd61705, 16'd61747,
    16'd61790, 16'd61832, 16'd61875, 16'd61919, 16'd61962,
    16'd62006, 16'd62051, 16'd62096, 16'd62141, 16'd62186,
    16'd62232, 16'd62279, 16'd62326, 16'd62374, 16'd62423,
    16'd62473, 16'd62523, 16'd62574, 16'd62626, 16'd62679,
    16'd62733, 16'd62789, 16'd62846, 16'd62905, 16'd62965,
    16'd63027, 16'd63092, 16'd63159, 16'd63229, 16'd63301,
    16'd63379, 16'd63460, 16'd63546, 16'd63639, 16'd63741,
    16'd63853, 16'd63979, 16'd64128, 16'd64311, 16'd64568,
    16'd65397
  };

  typedef struct packed {
    logic [15:0] count;
    logic        running;
    logic        enable;
    logic [6:0]  power;
  } tpac_state_t;

  // clamp to the last entry
  function automatic logic [15:0] delay_lookup(input logic [6:0] idx);
    logic [6:0] sel;
    sel = (idx >= 7'(TABLE_ENTRIES)) ? 7'(TABLE_ENTRIES - 1) : idx;
    return DELAY_TABLE[sel];
  endfunction

endpackage

[hdl/tpac_step.sv]
module tpac_step (
  input  tpac_pkg::tpac_state_t cur_i,
  input  logic [1:0]            action_i,
  input  logic                  key_on_off_i,
  input  logic                  key_up_i,
  input  logic                  key_down_i,
  output tpac_pkg::tpac_state_t nxt_o,
  output logic                  fire_o
);
  import tpac_pkg::*;

  logic       en_k;
  logic [6:0] p_up;
  logic [6:0] p_dn;

  // key handling: toggle first, then up, then down
  always_comb begin
    en_k = key_on_off_i ? ~cur_i.enable : cur_i.enable;
    p_up = cur_i.power;
    if (key_up_i && en_k) begin
      p_up = (cur_i.power >= PWR_MAX) ? PWR_MAX : cur_i.power + 7'd1;
    end
    p_dn = p_up;
    if (key_down_i && en_k) begin
      p_dn = (p_up <= PWR_MIN) ? PWR_MIN : p_up - 7'd1;
    end
  end

  always_comb begin
    nxt_o  = cur_i;
    fire_o = 1'b0;
    case (action_i)
      ACT_TICK: begin
        if (cur_i.running) begin
          if (cur_i.count == COUNT_LAST) begin
            fire_o        = 1'b1;
            nxt_o.running = 1'b0;
            nxt_o.count   = delay_lookup(cur_i.power);
          end else begin
            nxt_o.count = cur_i.count + 16'd1;
          end
        end
      end
      ACT_ZCROSS: begin
        if (cur_i.enable) begin
          nxt_o.running = 1'b1;
        end
      end
      ACT_KEY: begin
        nxt_o.enable = en_k;
        nxt_o.power  = p_dn;
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

endmodule

[hdl/triac_phase_angle_controller_core.sv]
// phase-angle triac firing controller
// input channel: in_valid / in_stall carry one event per beat (timer tick,
//   mains zero crossing or key change, with the three key bits)
// output channel: out_valid / out_stall carry one result beat per event:
//   fire pulse, enable, power level and timer running, all after the event
// path: an accepted beat is loaded into the input register, then the
//   state update runs as it moves on into the result register, which
//   drives out_*
// throughput: one event per cycle while out_stall is low; the state update
//   is a single pass of the step logic, so ticks may arrive every clock
// when out_stall is high the result register holds; the input register
//   still takes one more beat, then in_stall rises until the result is taken
// reset (rst_n low at a clock edge): timer stopped at count zero, output
//   disabled, power level fifty, both pipeline stages empty
// no configuration registers
module triac_phase_angle_controller_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic       in_key_on_off,
  input  logic       in_key_up,
  input  logic       in_key_down,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_fire_pulse,
  output logic       out_output_enabled,
  output logic [6:0] out_power_level,
  output logic       out_timer_active
);
  import tpac_pkg::*;

  `include "triac_phase_angle_controller_core_assert.svh"

  // input stage
  logic       s1_vld_r;
  logic [1:0] s1_action_r;
  logic       s1_on_off_r;
  logic       s1_up_r;
  logic       s1_down_r;

  // controller state
  tpac_state_t state_r;
  tpac_state_t state_nxt;
  logic        fire_nxt;

  // result stage
  logic       out_vld_r;
  logic       out_fire_r;
  logic       out_en_r;
  logic [6:0] out_pwr_r;
  logic       out_run_r;

  logic adv;   // result register free this cycle
  logic go;    // input stage retires into the result register
  logic in_acc;

  assign adv    = ~out_vld_r | ~out_stall;
  assign go     = s1_vld_r & adv;
  assign in_stall = s1_vld_r & ~adv;
  assign in_acc = in_valid & ~in_stall;

  // input register, holds a beat while the result side is blocked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action_r <= in_action;
      s1_on_off_r <= in_key_on_off;
      s1_up_r     <= in_key_up;
      s1_down_r   <= in_key_down;
    end
  end

  // next state and fire decision for the event in the input register
  tpac_step u_step (
    .cur_i        (state_r),
    .action_i     (s1_action_r),
    .key_on_off_i (s1_on_off_r),
    .key_up_i     (s1_up_r),
    .key_down_i   (s1_down_r),
    .nxt_o        (state_nxt),
    .fire_o       (fire_nxt)
  );

  // state only moves when an event retires, keeping results in order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.count   <= '0;
      state_r.running <= 1'b0;
      state_r.enable  <= 1'b0;
      state_r.power   <= PWR_RESET;
    end else if (go) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_fire_r <= fire_nxt;
      out_en_r   <= state_nxt.enable;
      out_pwr_r  <= state_nxt.power;
      out_run_r  <= state_nxt.running;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_fire_pulse     = out_fire_r;
  assign out_output_enabled = out_en_r;
  assign out_power_level    = out_pwr_r;
  assign out_timer_active   = out_run_r;

  // power level stays within its saturation limits
  `TPAC_ASSERT_NOW(a_pwr_range, out_vld_r,
    (out_pwr_r >= PWR_MIN) && (out_pwr_r <= PWR_MAX), "power level out of range")
  // a fire beat always stops the timer
  `TPAC_ASSERT_NOW(a_fire_stops, out_vld_r && out_fire_r, !out_run_r,
    "timer still running after fire")
  // fire only on wrap of a running timer
  `TPAC_ASSERT_NOW(a_fire_wrap, go && fire_nxt,
    state_r.running && (state_r.count == COUNT_LAST), "fire without timer wrap")
  // state holds unless an event retires
  `TPAC_ASSERT_NEXT(a_state_hold, !go, $stable(state_r), "state moved without event")

endmodule
